### src/pipqw_pkg.sv
// Package: shared widths and the queue item type for the point-in-polygon winding test.
package pipqw_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = 13;

  // Quadrant step codes, new quadrant minus previous quadrant modulo 4
  localparam logic [1:0] QSTEP_SAME = 2'd0;
  localparam logic [1:0] QSTEP_CCW  = 2'd1;
  localparam logic [1:0] QSTEP_OPP  = 2'd2;
  localparam logic [1:0] QSTEP_CW   = 2'd3;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] pdx;
    logic signed [DIFF_W-1:0] pdy;
    logic [1:0]               qstep;
    logic                     first;
    logic                     last;
  } pipqw_item_t;

endpackage

### src/pipqw_front.sv
// Front end: latches the query point and forms relative vertex coordinates and quadrant step.
module pipqw_front
  import pipqw_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic signed [COORD_W-1:0]  vertex_x,
  input  logic signed [COORD_W-1:0]  vertex_y,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  input  logic                       first,
  input  logic                       last,
  output pipqw_item_t                item
);

  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic signed [DIFF_W-1:0]  prev_dx;
  logic signed [DIFF_W-1:0]  prev_dy;
  logic signed [COORD_W-1:0] ref_x;
  logic signed [COORD_W-1:0] ref_y;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic [1:0]                quad;
  logic [1:0]                prev_quad;

  function automatic logic [1:0] quadrant(input logic neg_x, input logic neg_y);
    logic [1:0] q;
    if (!neg_x) q = neg_y ? 2'd3 : 2'd0;
    else        q = neg_y ? 2'd2 : 2'd1;
    return q;
  endfunction

  always_comb begin
    ref_x     = first ? point_x : query_x;
    ref_y     = first ? point_y : query_y;
    dx        = {vertex_x[COORD_W-1], vertex_x} - {ref_x[COORD_W-1], ref_x};
    dy        = {vertex_y[COORD_W-1], vertex_y} - {ref_y[COORD_W-1], ref_y};
    quad      = quadrant(dx[DIFF_W-1], dy[DIFF_W-1]);
    prev_quad = quadrant(prev_dx[DIFF_W-1], prev_dy[DIFF_W-1]);
    item.dx    = dx;
    item.dy    = dy;
    item.pdx   = prev_dx;
    item.pdy   = prev_dy;
    item.qstep = quad - prev_quad;
    item.first = first;
    item.last  = last;
  end

  // The previous vertex always tracks the last accepted item; once the walk stops,
  // later items are ignored until the next first, so no stop feedback is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      prev_dx <= '0;
      prev_dy <= '0;
    end else if (accept) begin
      if (first) begin
        query_x <= point_x;
        query_y <= point_y;
      end
      prev_dx <= dx;
      prev_dy <= dy;
    end
  end

endmodule

### src/pipqw_fifo.sv
// Two-entry queue of classified vertex items between front and back.
module pipqw_fifo
  import pipqw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pipqw_item_t push_item,
  input  logic        pop,
  output pipqw_item_t pop_item,
  output logic        full,
  output logic        empty
);

  pipqw_item_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/pipqw_back.sv
// Back end: cross products, stop detection, winding sum and the result register.
module pipqw_back
  import pipqw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  pipqw_item_t q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        inside_res,
  output logic        on_boundary
);

  // product stage
  logic                     s1_valid;
  logic signed [PROD_W-1:0] s1_m1;
  logic signed [PROD_W-1:0] s1_m2;
  logic signed [DIFF_W-1:0] s1_dx;
  logic signed [DIFF_W-1:0] s1_dy;
  logic signed [DIFF_W-1:0] s1_pdx;
  logic signed [DIFF_W-1:0] s1_pdy;
  logic [1:0]               s1_qstep;
  logic                     s1_first;
  logic                     s1_last;

  // walk state
  logic [SUM_W-1:0] winding_sum;
  logic             stopped;
  logic [SUM_W-1:0] winding_sum_next;
  logic             stopped_next;

  logic                     adv;
  logic                     s1_load;
  logic signed [PROD_W:0]   f;
  logic                     f_pos;
  logic                     f_zero;
  logic                     on_point;
  logic                     nonpos_x;
  logic                     nonpos_y;

  assign adv     = s1_valid && (!s1_last || !out_valid || out_ready);
  assign s1_load = !s1_valid || adv;
  assign q_pop   = s1_load && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_m1    <= q_item.dy * q_item.pdx;
      s1_m2    <= q_item.dx * q_item.pdy;
      s1_dx    <= q_item.dx;
      s1_dy    <= q_item.dy;
      s1_pdx   <= q_item.pdx;
      s1_pdy   <= q_item.pdy;
      s1_qstep <= q_item.qstep;
      s1_first <= q_item.first;
      s1_last  <= q_item.last;
    end
  end

  always_comb begin
    f        = {s1_m1[PROD_W-1], s1_m1} - {s1_m2[PROD_W-1], s1_m2};
    f_zero   = (f == '0);
    f_pos    = !f[PROD_W] && !f_zero;
    on_point = (s1_dx == '0) && (s1_dy == '0);
    nonpos_x = (s1_pdx == '0) || (s1_dx == '0) || (s1_pdx[DIFF_W-1] != s1_dx[DIFF_W-1]);
    nonpos_y = (s1_pdy == '0) || (s1_dy == '0) || (s1_pdy[DIFF_W-1] != s1_dy[DIFF_W-1]);

    winding_sum_next = winding_sum;
    stopped_next     = stopped;
    if (s1_first) begin
      winding_sum_next = '0;
      stopped_next     = 1'b0;
    end else if (!stopped) begin
      if (on_point || (f_zero && nonpos_x && nonpos_y)) begin
        stopped_next = 1'b1;
      end else begin
        case (s1_qstep)
          QSTEP_CCW: winding_sum_next = winding_sum + SUM_W'(1);
          QSTEP_CW:  winding_sum_next = winding_sum - SUM_W'(1);
          QSTEP_OPP: winding_sum_next = f_pos ? winding_sum + SUM_W'(2)
                                              : winding_sum - SUM_W'(2);
          default:   winding_sum_next = winding_sum;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      winding_sum <= '0;
      stopped     <= 1'b0;
    end else if (adv) begin
      winding_sum <= winding_sum_next;
      stopped     <= stopped_next;
    end
  end

  // hold the result until taken; non-last items keep flowing meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last) begin
      inside_res  <= stopped_next || (winding_sum_next != '0);
      on_boundary <= stopped_next;
    end
  end

endmodule

### src/point_in_polygon_quadrant_winding.sv
// The item marked last passes through the queue and the product stage; its result is then held in the output register.
// Throughput: one vertex item per cycle; front, queue and back stall separately.
// The back end multiplies in one stage and updates the winding state in the next.
// Reset (rst, synchronous, active high) clears the query point, the previous
// vertex, the winding sum, the stop flag, the queue and all valid flags.
module point_in_polygon_quadrant_winding
  import pipqw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // vertex_x, vertex_y, point_x, point_y
  input  logic        s_tlast,  // last
  input  logic        s_tuser,  // first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // inside_res, on_boundary, zero padding
);

  pipqw_item_t front_item;
  pipqw_item_t q_item;
  logic        accept;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic        inside_res;
  logic        on_boundary;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {6'b0, on_boundary, inside_res};

  pipqw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .vertex_x (s_tdata[15:0]),
    .vertex_y (s_tdata[31:16]),
    .point_x  (s_tdata[47:32]),
    .point_y  (s_tdata[63:48]),
    .first    (s_tuser),
    .last     (s_tlast),
    .item     (front_item)
  );

  pipqw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  pipqw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .inside_res  (inside_res),
    .on_boundary (on_boundary)
  );

endmodule
